// File: rtl/mrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared constants and helper functions for the serial slave responder:
// function codes, reset values, register reset table and CRC-16 update.
// ----------------------------------------------------------------------------
package mrs_pkg;

  localparam int unsigned NUM_REGS_DEFAULT = 10;

  localparam logic [7:0] SLAVE_ADDR_RESET = 8'h01;

  localparam logic [7:0] FC_READ_COILS    = 8'h01;
  localparam logic [7:0] FC_READ_DISCRETE = 8'h02;
  localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
  localparam logic [7:0] FC_READ_INPUT    = 8'h04;
  localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [15:0] COIL_BITS_RESET     = 16'h0315;
  localparam logic [15:0] DISCRETE_BITS_RESET = 16'h0315;

  function automatic logic [15:0] reg_reset_val(input logic [3:0] idx);
    logic [15:0] v;
    unique case (idx)
      4'd0:    v = 16'd1234;
      4'd1:    v = 16'd4567;
      4'd2:    v = 16'd6789;
      4'd3:    v = 16'd9876;
      4'd4:    v = 16'd6543;
      4'd5:    v = 16'd4321;
      4'd6:    v = 16'd3210;
      4'd7:    v = 16'd2221;
      4'd8:    v = 16'd2580;
      4'd9:    v = 16'd9156;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/modbus_rtu_slave_responder.sv
`default_nettype none
// Timing: the eighth request byte is decoded in the cycle after it is taken; then one response
// item leaves per cycle unless out_ready stalls the output; register reads also pass through
// an extra state (S_RD) per register for the synchronous holding memory read.
// Framing: 8 request items per frame, response length 0 to 25 items at NUM_REGS = 10; no new item is
// taken until the last response item is in the output register.
// Reset: synchronous; position, state, valid bits and output valid clear; address returns to 1.
// ----------------------------------------------------------------------------
// modbus_rtu_slave_responder
// Groups received bytes into eight-byte requests, serves bit reads, register
// reads and single register writes, and streams the reply with its CRC-16.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_responder #(
  parameter int unsigned NUM_REGS = mrs_pkg::NUM_REGS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] tx_byte,
  output logic            frame_end,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] slave_address
);

  localparam int unsigned IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned QW = $clog2(NUM_REGS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_HDR    = 4'd2;
  localparam logic [3:0] S_COIL   = 4'd3;
  localparam logic [3:0] S_RD     = 4'd4;
  localparam logic [3:0] S_HI     = 4'd5;
  localparam logic [3:0] S_LO     = 4'd6;
  localparam logic [3:0] S_CRC_LO = 4'd7;
  localparam logic [3:0] S_CRC_HI = 4'd8;

  localparam logic [1:0] K_COIL = 2'd0;
  localparam logic [1:0] K_REG  = 2'd1;
  localparam logic [1:0] K_ECHO = 2'd2;

  logic [3:0]  state;
  logic [7:0]  station_addr;
  logic [7:0]  frame [7];
  logic [2:0]  pos;
  logic [1:0]  kind;
  logic [2:0]  hdr_idx;
  logic [7:0]  fc_r;
  logic [7:0]  count_r;
  logic [15:0] coil_word;
  logic        coil_idx;
  logic [1:0]  coil_left;
  logic [IW-1:0] rd_idx;
  logic [QW-1:0] rd_left;
  logic        rd_input;
  logic [15:0] crc;

  logic [15:0]         holding_mem [NUM_REGS];
  logic [NUM_REGS-1:0] hold_valid;
  logic [15:0]         mem_q;
  logic                mem_q_valid;
  logic [15:0]         mem_q_def;
  logic                mem_q_input;

  logic [15:0] rd_word;
  logic        slot_free;
  logic        emit_go;
  logic        emit_crc;
  logic        emit_end;
  logic [7:0]  emit_byte;
  logic [7:0]  hdr_byte;

  logic [7:0]  dec_fc;
  logic [15:0] dec_addr;
  logic [15:0] dec_qty;
  logic [16:0] dec_sum;
  logic        dec_range_ok;
  logic [QW-1:0] dec_qn;
  logic [5:0]  dec_bc;
  logic [15:0] dec_bits;
  logic        mem_we;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;

  assign dec_fc       = frame[1];
  assign dec_addr     = {frame[2], frame[3]};
  assign dec_qty      = {frame[4], frame[5]};
  assign dec_sum      = {1'b0, dec_addr} + {1'b0, dec_qty};
  assign dec_range_ok = (dec_sum <= 17'(NUM_REGS));
  assign dec_qn       = dec_qty[QW-1:0];
  assign dec_bc       = (6'(dec_qn) + 6'd7) >> 3;
  assign dec_bits     = (dec_fc == mrs_pkg::FC_READ_COILS) ? mrs_pkg::COIL_BITS_RESET
                                                           : mrs_pkg::DISCRETE_BITS_RESET;
  assign mem_we       = (state == S_DECODE) && (frame[0] == station_addr)
                        && (dec_fc == mrs_pkg::FC_WRITE_SINGLE)
                        && (dec_addr < 16'(NUM_REGS));

  assign rd_word = (mem_q_input || !mem_q_valid) ? mem_q_def : mem_q;

  // holding register memory; undefined entries, and every input register read, return reset values
  always_ff @(posedge clk) begin
    if (mem_we) begin
      holding_mem[dec_addr[IW-1:0]] <= dec_qty;
    end
    if (state == S_RD) begin
      mem_q       <= holding_mem[rd_idx];
      mem_q_valid <= hold_valid[rd_idx];
      mem_q_def   <= mrs_pkg::reg_reset_val(4'(rd_idx));
      mem_q_input <= rd_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= '0;
    end else if (mem_we) begin
      hold_valid[dec_addr[IW-1:0]] <= 1'b1;
    end
  end

  always_comb begin
    unique case (hdr_idx)
      3'd0:    hdr_byte = station_addr;
      3'd1:    hdr_byte = fc_r;
      default: hdr_byte = count_r;
    endcase
    if (kind == K_ECHO) begin
      hdr_byte = (hdr_idx < 3'd6) ? frame[hdr_idx] : 8'h00;
    end
  end

  always_comb begin
    emit_go   = 1'b0;
    emit_crc  = 1'b1;
    emit_end  = 1'b0;
    emit_byte = 8'h00;
    unique case (state)
      S_HDR: begin
        emit_go   = slot_free;
        emit_byte = hdr_byte;
      end
      S_COIL: begin
        emit_go   = slot_free;
        emit_byte = coil_idx ? coil_word[15:8] : coil_word[7:0];
      end
      S_HI: begin
        emit_go   = slot_free;
        emit_byte = rd_word[15:8];
      end
      S_LO: begin
        emit_go   = slot_free;
        emit_byte = rd_word[7:0];
      end
      S_CRC_LO: begin
        emit_go   = slot_free;
        emit_crc  = 1'b0;
        emit_byte = crc[7:0];
      end
      S_CRC_HI: begin
        emit_go   = slot_free;
        emit_crc  = 1'b0;
        emit_end  = 1'b1;
        emit_byte = crc[15:8];
      end
      default: begin
        emit_go = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (emit_go) begin
      tx_byte   <= emit_byte;
      frame_end <= emit_end;
      if (emit_crc) begin
        crc <= mrs_pkg::crc_byte(crc, emit_byte);
      end
    end else if (state == S_DECODE) begin
      crc <= mrs_pkg::CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      station_addr <= mrs_pkg::SLAVE_ADDR_RESET;
    end else if (cfg_valid) begin
      station_addr <= slave_address;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && pos != 3'd7) begin
      frame[pos] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos   <= 3'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (pos == 3'd7) begin
              pos   <= 3'd0;
              state <= S_DECODE;
            end else begin
              pos <= pos + 3'd1;
            end
          end
        end
        S_DECODE: begin
          hdr_idx   <= 3'd0;
          fc_r      <= dec_fc;
          coil_idx  <= 1'b0;
          coil_left <= dec_bc[1:0];
          coil_word <= (dec_bits >> dec_addr[3:0]) & 16'(~(17'h1FFFF << dec_qn));
          rd_idx    <= dec_addr[IW-1:0];
          rd_left   <= dec_qn;
          rd_input  <= (dec_fc == mrs_pkg::FC_READ_INPUT);
          if (frame[0] != station_addr) begin
            state <= S_IDLE;
          end else if ((dec_fc == mrs_pkg::FC_READ_COILS
                        || dec_fc == mrs_pkg::FC_READ_DISCRETE) && dec_range_ok) begin
            kind    <= K_COIL;
            count_r <= 8'(dec_bc);
            state   <= S_HDR;
          end else if ((dec_fc == mrs_pkg::FC_READ_HOLDING
                        || dec_fc == mrs_pkg::FC_READ_INPUT) && dec_range_ok) begin
            kind    <= K_REG;
            count_r <= 8'({dec_qn, 1'b0});
            state   <= S_HDR;
          end else if (dec_fc == mrs_pkg::FC_WRITE_SINGLE) begin
            kind  <= K_ECHO;
            state <= S_HDR;
          end else begin
            state <= S_IDLE;
          end
        end
        S_HDR: begin
          if (emit_go) begin
            hdr_idx <= hdr_idx + 3'd1;
            if (kind == K_ECHO) begin
              if (hdr_idx == 3'd5) begin
                state <= S_CRC_LO;
              end
            end else if (hdr_idx == 3'd2) begin
              if (kind == K_COIL) begin
                state <= (coil_left == 2'd0) ? S_CRC_LO : S_COIL;
              end else begin
                state <= (rd_left == '0) ? S_CRC_LO : S_RD;
              end
            end
          end
        end
        S_COIL: begin
          if (emit_go) begin
            coil_idx  <= 1'b1;
            coil_left <= coil_left - 2'd1;
            if (coil_left == 2'd1) begin
              state <= S_CRC_LO;
            end
          end
        end
        S_RD: begin
          state <= S_HI;
        end
        S_HI: begin
          if (emit_go) begin
            state <= S_LO;
          end
        end
        S_LO: begin
          if (emit_go) begin
            rd_idx  <= rd_idx + IW'(1);
            rd_left <= rd_left - QW'(1);
            state   <= (rd_left == QW'(1)) ? S_CRC_LO : S_RD;
          end
        end
        S_CRC_LO: begin
          if (emit_go) begin
            state <= S_CRC_HI;
          end
        end
        S_CRC_HI: begin
          if (emit_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: tb/mrs_reply_checker.sv
// ----------------------------------------------------------------------------
// mrs_reply_checker
// Watches the request, reply and station-address channels of the serial
// slave responder. Keeps its own copy of the request buffer, register
// stores and bit images, builds the expected reply with its CRC-16 for
// every answered eight-byte request, and compares each reply item in order.
// ----------------------------------------------------------------------------
module mrs_reply_checker #(
  parameter int unsigned NUM_REGS = mrs_pkg::NUM_REGS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] tx_byte,
  input  logic       frame_end,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] slave_address,
  output int         mismatches,
  output int         pending_replies
);
  import mrs_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_item_t;

  localparam logic [16*10-1:0] REG_INIT = {
    16'd9156, 16'd2580, 16'd2221, 16'd3210, 16'd4321,
    16'd6543, 16'd9876, 16'd6789, 16'd4567, 16'd1234
  };

  reply_item_t reply_bytes_q[$];
  logic [7:0]  station;
  logic [7:0]  req [0:6];
  logic [2:0]  req_count;
  logic [15:0] holding [0:15];
  logic [15:0] input_regs [0:15];
  logic [15:0] coils;
  logic [15:0] discretes;

  initial mismatches = 0;
  initial pending_replies = 0;

  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ d[i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic absorb_request_byte(input logic [7:0] b);
    logic [7:0]  resp [0:39];
    logic [7:0]  fc;
    logic [15:0] a;
    logic [15:0] q;
    logic [15:0] bits;
    logic [15:0] v;
    logic [15:0] crc;
    logic [16:0] span;
    int          n;
    if (req_count != 3'd7) begin
      req[req_count] = b;
      req_count = req_count + 3'd1;
      return;
    end
    req_count = 3'd0;
    if (req[0] != station) return;
    fc = req[1];
    a = {req[2], req[3]};
    q = {req[4], req[5]};
    span = {1'b0, a} + {1'b0, q};
    for (int k = 0; k < 40; k++) resp[k] = 8'h00;
    resp[0] = station;
    resp[1] = fc;
    case (fc)
      FC_READ_COILS, FC_READ_DISCRETE: begin
        if (span > NUM_REGS) return;
        bits = (fc == FC_READ_COILS) ? coils : discretes;
        n = 3 + (int'(q) + 7) / 8;
        resp[2] = 8'(n - 3);
        for (int k = 0; k < int'(q); k++) begin
          if (bits[(int'(a) + k) % 16]) resp[3 + k / 8][k % 8] = 1'b1;
        end
      end
      FC_READ_HOLDING, FC_READ_INPUT: begin
        if (span > NUM_REGS) return;
        resp[2] = 8'(int'(q) * 2);
        for (int k = 0; k < int'(q); k++) begin
          v = (fc == FC_READ_HOLDING) ? holding[(int'(a) + k) % 16]
                                      : input_regs[(int'(a) + k) % 16];
          resp[3 + 2 * k] = v[15:8];
          resp[4 + 2 * k] = v[7:0];
        end
        n = 3 + 2 * int'(q);
      end
      FC_WRITE_SINGLE: begin
        if (a < NUM_REGS) holding[a % 16] = q;
        for (int k = 0; k < 6; k++) resp[k] = req[k];
        n = 6;
      end
      default: return;
    endcase
    crc = CRC_INIT;
    for (int k = 0; k < n; k++) begin
      crc = crc16_next(crc, resp[k]);
      reply_bytes_q.push_back('{data: resp[k], last: 1'b0});
    end
    reply_bytes_q.push_back('{data: crc[7:0], last: 1'b0});
    reply_bytes_q.push_back('{data: crc[15:8], last: 1'b1});
  endtask

  always @(posedge clk) begin
    reply_item_t exp_item;
    if (rst) begin
      station = SLAVE_ADDR_RESET;
      req_count = 3'd0;
      for (int i = 0; i < 16; i++) begin
        holding[i] = (i < 10) ? REG_INIT[16 * i +: 16] : 16'd0;
        input_regs[i] = holding[i];
      end
      for (int i = 0; i < 7; i++) req[i] = 8'h00;
      coils = COIL_BITS_RESET;
      discretes = DISCRETE_BITS_RESET;
      reply_bytes_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (reply_bytes_q.size() == 0) begin
          mismatches++;
          $display("%0t: reply item, expected none, actual data %h end %b",
                   $time, tx_byte, frame_end);
        end else begin
          exp_item = reply_bytes_q.pop_front();
          if (tx_byte !== exp_item.data) begin
            mismatches++;
            $display("%0t: tx_byte mismatch, expected %h, actual %h",
                     $time, exp_item.data, tx_byte);
          end
          if (frame_end !== exp_item.last) begin
            mismatches++;
            $display("%0t: frame_end mismatch, expected %b, actual %b",
                     $time, exp_item.last, frame_end);
          end
        end
      end
      if (cfg_valid && cfg_ready) station = slave_address;
      if (in_valid && in_ready) absorb_request_byte(rx_byte);
    end
    pending_replies <= reply_bytes_q.size();
  end

endmodule

// File: tb/tb_modbus_rtu_slave_responder.sv
// ----------------------------------------------------------------------------
// tb_modbus_rtu_slave_responder
// Drives request frames into the serial slave responder: a directed set of
// bit reads, register reads, writes, range edges and ignored frames, then
// random frames mixed with stray bytes, under several station addresses and
// idle/stall mixes, including a long reply hold-off. The checker module
// predicts and compares every reply item.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_slave_responder;
  import mrs_pkg::*;

  localparam int unsigned NUM_REGS = NUM_REGS_DEFAULT;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_LEN = 300;
  localparam int DRAIN_GAP = 64;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] tx_byte;
  logic       frame_end;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] slave_address = SLAVE_ADDR_RESET;

  int         mismatches;
  int         pending_replies;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         hold_reqs = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         quiet = 0;
  int         sent = 0;
  logic [7:0] station = SLAVE_ADDR_RESET;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  modbus_rtu_slave_responder #(.NUM_REGS(NUM_REGS)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tx_byte      (tx_byte),
    .frame_end    (frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .slave_address(slave_address)
  );

  mrs_reply_checker #(.NUM_REGS(NUM_REGS)) reply_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tx_byte        (tx_byte),
    .frame_end      (frame_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .slave_address  (slave_address),
    .mismatches     (mismatches),
    .pending_replies(pending_replies)
  );

  // reply side: random stalls plus a single long hold-off
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("modbus_rtu_slave_responder verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [7:0] fc,
                            input logic [15:0] a, input logic [15:0] q);
    send_byte(id);
    send_byte(fc);
    send_byte(a[15:8]);
    send_byte(a[7:0]);
    send_byte(q[15:8]);
    send_byte(q[7:0]);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_station(input logic [7:0] v);
    cfg_valid <= 1'b1;
    slave_address <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    station = v;
  endtask

  task automatic random_frame();
    logic [7:0]  id;
    logic [7:0]  fc;
    logic [15:0] a;
    logic [15:0] q;
    int          r;
    // stray bytes break framing now and then
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(5, 1)) send_byte(8'($urandom));
    end
    while (sent % 8 != 0) send_byte(8'($urandom));
    id = ($urandom_range(99) < 90) ? station : 8'($urandom);
    r = $urandom_range(99);
    if (r < 18) fc = FC_READ_COILS;
    else if (r < 36) fc = FC_READ_DISCRETE;
    else if (r < 54) fc = FC_READ_HOLDING;
    else if (r < 72) fc = FC_READ_INPUT;
    else if (r < 92) fc = FC_WRITE_SINGLE;
    else fc = 8'($urandom);
    a = 16'($urandom_range(NUM_REGS));
    if ($urandom_range(9) == 0) a = 16'($urandom);
    if (fc == FC_WRITE_SINGLE || a > NUM_REGS || $urandom_range(9) == 0) begin
      q = 16'($urandom);
    end else begin
      q = 16'($urandom_range(NUM_REGS - a));
    end
    send_frame(id, fc, a, q);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_frame(station, FC_READ_COILS, 16'd0, 16'd10);
    send_frame(station, FC_READ_DISCRETE, 16'd3, 16'd7);
    send_frame(station, FC_READ_HOLDING, 16'd0, 16'd10);
    send_frame(station, FC_WRITE_SINGLE, 16'd9, 16'hFFFF);
    send_frame(station, FC_READ_INPUT, 16'd9, 16'd1);
    send_frame(station, FC_WRITE_SINGLE, 16'd10, 16'h0000);
    send_frame(station, FC_READ_HOLDING, 16'd10, 16'd0);
    send_frame(station, FC_READ_COILS, 16'd5, 16'd6);
    send_frame(station, FC_READ_HOLDING, 16'hFFFF, 16'h0001);
    send_frame(station, 8'hFF, 16'd0, 16'd1);
    send_frame(8'h00, FC_READ_HOLDING, 16'd0, 16'd1);
    drain();

    write_station(8'd247);
    repeat (3) send_frame(station, FC_READ_HOLDING, 16'd0, 16'd10);
    hold_reqs <= hold_reqs + 1;
    repeat (6) random_frame();
    drain();

    write_station(8'h5A);
    send_idle_pct = 51;
    repeat (5) random_frame();
    drain();

    write_station(8'h24);
    send_idle_pct = 0;
    stall_pct <= 51;
    repeat (3) random_frame();
    drain();
    repeat (3) random_frame();
    drain();

    write_station(SLAVE_ADDR_RESET);
    send_idle_pct = 10;
    stall_pct <= 10;
    repeat (6) random_frame();
    drain();

    if (mismatches == 0 && pending_replies == 0) begin
      $display("modbus_rtu_slave_responder verification clean");
    end else begin
      $display("modbus_rtu_slave_responder verification failed");
    end
    $finish;
  end

endmodule
